// ----- rtl/core/rdt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_pkg
// Shared types and constants for the record duplicate tracker.
// ----------------------------------------------------------------------------
package rdt_pkg;

    // Default bitmap size in records
    localparam int DEF_MAX_RECORDS = 65536;

    // Bitmap row width: records per memory word
    localparam int ROW_BITS = 8;
    localparam int BIT_W    = $clog2(ROW_BITS);

    // Field widths
    localparam int REC_W = 17;   // record count, received and missing counts
    localparam int TOT_W = 32;   // invalid and duplicate totals
    localparam int ID_W  = 64;

    localparam logic [REC_W-1:0] RECV_MAX      = {REC_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX       = {TOT_W{1'b1}};
    localparam logic [REC_W-1:0] COUNT_RST_VAL = 17'd65536;

    // Request codes
    localparam logic REQ_RECORD  = 1'b0;
    localparam logic REQ_SESSION = 1'b1;

    // Result classification
    typedef enum logic [1:0] {
        OUT_UNIQUE    = 2'd0,
        OUT_DUPLICATE = 2'd1,
        OUT_INVALID   = 2'd2,
        OUT_SUMMARY   = 2'd3
    } outcome_t;

    // Classification event from the lookup control to the tally unit
    typedef struct packed {
        logic     valid;
        outcome_t outcome;
    } tally_ev_t;

endpackage

// ----- rtl/core/rdt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module rdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/rdt_tally.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_tally
// Session totals and the registered result port.
// ----------------------------------------------------------------------------
module rdt_tally import rdt_pkg::*; #(
    parameter int CNT_W = REC_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tally_ev_t        ev,
    input  logic [CNT_W-1:0] eff_count,
    output logic             done,
    output logic [1:0]       outcome,
    output logic [REC_W-1:0] received_count,
    output logic [TOT_W-1:0] invalid_count,
    output logic [TOT_W-1:0] duplicate_count,
    output logic [REC_W-1:0] missing_count
);

    logic [REC_W-1:0] recv_reg, recv_next, recv_upd;
    logic [TOT_W-1:0] inv_reg, inv_next, inv_upd;
    logic [TOT_W-1:0] dup_reg, dup_next, dup_upd;
    logic [CNT_W-1:0] recv_ext;
    logic [CNT_W-1:0] miss_diff;
    logic [REC_W-1:0] miss_val;

    logic             done_reg;
    logic [1:0]       outcome_reg;
    logic [REC_W-1:0] recv_out_reg;
    logic [TOT_W-1:0] inv_out_reg;
    logic [TOT_W-1:0] dup_out_reg;
    logic [REC_W-1:0] miss_out_reg;

    // Saturating update for the classified item
    always_comb
    begin
        recv_upd = recv_reg;
        inv_upd  = inv_reg;
        dup_upd  = dup_reg;
        case (ev.outcome)
            OUT_UNIQUE:
            begin
                if (recv_reg != RECV_MAX)
                    recv_upd = recv_reg + REC_W'(1);
            end
            OUT_DUPLICATE:
            begin
                if (dup_reg != TOT_MAX)
                    dup_upd = dup_reg + TOT_W'(1);
            end
            OUT_INVALID:
            begin
                if (inv_reg != TOT_MAX)
                    inv_upd = inv_reg + TOT_W'(1);
            end
            default: ;  // summary reports totals unchanged
        endcase
    end

    // Next totals: session end clears them after the report
    always_comb
    begin
        recv_next = recv_reg;
        inv_next  = inv_reg;
        dup_next  = dup_reg;
        if (ev.valid)
        begin
            if (ev.outcome == OUT_SUMMARY)
            begin
                recv_next = '0;
                inv_next  = '0;
                dup_next  = '0;
            end
            else
            begin
                recv_next = recv_upd;
                inv_next  = inv_upd;
                dup_next  = dup_upd;
            end
        end
    end

    // Missing count, floored at zero and saturated to the field width
    always_comb
    begin
        recv_ext  = CNT_W'(recv_upd);
        miss_diff = eff_count - recv_ext;
        if (eff_count <= recv_ext)
            miss_val = '0;
        else if (miss_diff > CNT_W'(RECV_MAX))
            miss_val = RECV_MAX;
        else
            miss_val = miss_diff[REC_W-1:0];
    end

    // Totals and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_reg <= '0;
            inv_reg  <= '0;
            dup_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            recv_reg <= recv_next;
            inv_reg  <= inv_next;
            dup_reg  <= dup_next;
            done_reg <= ev.valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ev.valid)
        begin
            outcome_reg  <= ev.outcome;
            recv_out_reg <= recv_upd;
            inv_out_reg  <= inv_upd;
            dup_out_reg  <= dup_upd;
            miss_out_reg <= miss_val;
        end
    end

    assign done            = done_reg;
    assign outcome         = outcome_reg;
    assign received_count  = recv_out_reg;
    assign invalid_count   = inv_out_reg;
    assign duplicate_count = dup_out_reg;
    assign missing_count   = miss_out_reg;

endmodule

// ----- rtl/core/record_duplicate_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_duplicate_tracker
// Classifies numbered records as unique, duplicate or invalid against a
// seen-bitmap and reports session totals on request.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item transfers on a rising edge with start high and
//   busy low. req_type selects a record (record_id, record_ok) or a session
//   end. Exactly one result follows each item, shown for one cycle with done
//   high; the receiver cannot stall, so results must be taken as they come.
//   Config: cfg_wr_en/cfg_wr_data write the expected session size (reset
//   65536); write it only while the block is idle.
//   Results: a record's result is registered from the lookup state after
//   its transfer; a session summary is registered from the transfer itself.
//   Records: busy is high during each lookup, so a new record waits for
//   the bitmap row's read-modify-write (RAM read, then modify and write back).
//   Session end and reset: the bitmap RAM is swept clear one row of ROW_BITS
//   records per cycle, all ceil(MAX_RECORDS / ROW_BITS) rows (8192 at the
//   default size), with busy held high. Config writes are taken throughout.
// ----------------------------------------------------------------------------
module record_duplicate_tracker import rdt_pkg::*; #(
    parameter int MAX_RECORDS = DEF_MAX_RECORDS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             req_type,
    input  logic [ID_W-1:0]  record_id,
    input  logic             record_ok,
    input  logic             cfg_wr_en,
    input  logic [REC_W-1:0] cfg_wr_data,
    output logic             done,
    output logic [1:0]       outcome,
    output logic [REC_W-1:0] received_count,
    output logic [TOT_W-1:0] invalid_count,
    output logic [TOT_W-1:0] duplicate_count,
    output logic [REC_W-1:0] missing_count
);

    localparam int ROWS   = (MAX_RECORDS + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MAX_CW = $clog2(MAX_RECORDS + 1);
    localparam int CNT_W  = (MAX_CW > REC_W) ? MAX_CW : REC_W;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t              state_reg, state_next;
    logic [ROW_AW-1:0]   sweep_reg, sweep_next;
    logic [REC_W-1:0]    session_size_reg;
    logic [ROW_AW-1:0]   row_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic                valid_reg;

    logic [CNT_W-1:0]    eff_count;
    logic                id_valid;
    logic                accept;
    logic                ram_we;
    logic [ROW_AW-1:0]   ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [ROW_BITS-1:0] ram_rdata;
    logic [ROW_BITS-1:0] bit_mask;
    logic                seen;
    tally_ev_t           ev;

    // Effective record count, capped at the bitmap size
    assign eff_count = (CNT_W'(session_size_reg) > CNT_W'(MAX_RECORDS)) ?
                       CNT_W'(MAX_RECORDS) : CNT_W'(session_size_reg);

    // Record validity at transfer
    assign id_valid = record_ok && (record_id[ID_W-1:CNT_W] == '0) &&
                      (record_id[CNT_W-1:0] < eff_count);

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Row lookup in the bitmap
    assign bit_mask = ROW_BITS'(1) << bit_reg;
    assign seen     = ram_rdata[bit_reg];

    // Control and bitmap write
    always_comb
    begin
        state_next  = state_reg;
        sweep_next  = sweep_reg;
        ev.valid    = 1'b0;
        ev.outcome  = OUT_SUMMARY;
        ram_we      = 1'b0;
        ram_waddr   = row_reg;
        ram_wdata   = ram_rdata | bit_mask;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = '0;
                if (sweep_reg == LAST_ROW)
                    state_next = ST_IDLE;
                else
                    sweep_next = sweep_reg + ROW_AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_SESSION)
                    begin
                        ev.valid   = 1'b1;
                        ev.outcome = OUT_SUMMARY;
                        sweep_next = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                ev.valid = 1'b1;
                if (!valid_reg)
                    ev.outcome = OUT_INVALID;
                else if (seen)
                    ev.outcome = OUT_DUPLICATE;
                else
                begin
                    ev.outcome = OUT_UNIQUE;
                    ram_we     = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, sweep counter and config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            sweep_reg        <= '0;
            session_size_reg <= COUNT_RST_VAL;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            if (cfg_wr_en)
                session_size_reg <= cfg_wr_data;
        end
    end

    // Item held for the lookup cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg   <= record_id[ROW_AW+BIT_W-1:BIT_W];
            bit_reg   <= record_id[BIT_W-1:0];
            valid_reg <= id_valid;
        end
    end

    // Seen-bitmap storage
    rdt_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS),
        .AW    (ROW_AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (record_id[ROW_AW+BIT_W-1:BIT_W]),
        .rd_data (ram_rdata)
    );

    // Totals and result register
    rdt_tally #(
        .CNT_W (CNT_W)
    ) u_tally (
        .clk             (clk),
        .rst_n           (rst_n),
        .ev              (ev),
        .eff_count       (eff_count),
        .done            (done),
        .outcome         (outcome),
        .received_count  (received_count),
        .invalid_count   (invalid_count),
        .duplicate_count (duplicate_count),
        .missing_count   (missing_count)
    );

endmodule

// ----- rtl/core/rdt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_checker
// Port-level checks on the duplicate tracker's command and result timing.
// ----------------------------------------------------------------------------
module rdt_checker import rdt_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       req_type,
    input logic       done,
    input logic [1:0] outcome
);

    // A record transfer locks out the next one for its lookup cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_RECORD) |=> busy)
        else $error("busy not raised after record transfer");

    // A record result follows its transfer after the lookup state and is no summary
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_RECORD) |=> ##1
        (done && outcome != OUT_SUMMARY))
        else $error("record result missing or misclassified");

    // A session end reports a summary next cycle while the map is swept
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_SESSION) |=>
        (done && outcome == OUT_SUMMARY && busy))
        else $error("session summary missing");

    // A record result shows while the block is ready for the next command
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && outcome != OUT_SUMMARY) |-> !busy)
        else $error("busy high with a record result");

endmodule

bind record_duplicate_tracker rdt_checker u_rdt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .done     (done),
    .outcome  (outcome)
);
